### hw/rtl/srp_pkg.sv
`default_nettype none

package srp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [31:0] FILE_CODE  = 32'd9994;
  localparam logic [6:0]  HEADER_LAST = 7'd99;
  localparam logic [32:0] BOX_LEN    = 33'd32;

  // global shape type codes as found in the file
  localparam logic [31:0] SHP_POINT    = 32'd1;
  localparam logic [31:0] SHP_POLYLINE = 32'd3;
  localparam logic [31:0] SHP_POLYGON  = 32'd5;

  // internal encoding of the global type
  localparam logic [1:0] FT_NONE     = 2'd0;
  localparam logic [1:0] FT_POINT    = 2'd1;
  localparam logic [1:0] FT_POLYLINE = 2'd2;
  localparam logic [1:0] FT_POLYGON  = 2'd3;

  typedef enum logic [3:0] {
    K_MINX      = 4'd0,
    K_MINY      = 4'd1,
    K_MAXX      = 4'd2,
    K_MAXY      = 4'd3,
    K_REC_START = 4'd4,
    K_PART      = 4'd5,
    K_POINT_X   = 4'd6,
    K_POINT_Y   = 4'd7,
    K_END       = 4'd8,
    K_ERROR     = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CODE  = 2'd1,
    ST_BAD_TYPE  = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] record_number;
    logic [63:0] value;
    logic [31:0] item_index;
    status_t     status;
    logic        last_of_run;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/srp_in_if.sv
`default_nettype none

interface srp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output first_byte, output final_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input final_byte,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/srp_out_if.sv
`default_nettype none

interface srp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [31:0] record_number;
  logic [63:0] value;
  logic [31:0] item_index;
  logic [1:0]  status;
  logic        last_of_run;

  modport source (output valid, output kind, output record_number, output value,
                  output item_index, output status, output last_of_run, input ready);
  modport sink   (input valid, input kind, input record_number, input value,
                  input item_index, input status, input last_of_run, output ready);
endinterface

`default_nettype wire

### hw/rtl/shapefile_record_parser.sv
// Shape file record parser.
// in_ch  : one byte of the file per item, with first_byte (restart at offset
//          zero) and final_byte (last byte of the file). valid/ready handshake.
// out_ch : result items (bounds, record starts, part indices, point x/y, end,
//          error), each with last_of_run set on the final result of its byte.
// Throughput: one byte per cycle while in_ch.ready is high. A byte gives
//          zero, one or two results; the parser state updates in the cycle
//          the byte is accepted and its results enter a small result queue
//          (QUEUE_DEPTH entries), and out_ch shows the oldest result in it.
// The queue drains one result per cycle while out_ch.ready is high.
// in_ch.ready is high while at least two queue entries are free; if the
// receiver stalls, the queue fills and in_ch.ready drops until results are
// taken. Nothing is dropped.
// After an error or an end result the parser gives no more results until a
// byte with first_byte set arrives.
// Reset (rst_n low, synchronous) empties the queue and returns the parser to
// the file header at offset zero.
`default_nettype none

module shapefile_record_parser #(
  parameter int unsigned QUEUE_DEPTH = srp_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  srp_in_if.sink    in_ch,
  srp_out_if.source out_ch
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(QUEUE_DEPTH - 2);

  typedef enum logic [3:0] {
    PH_HEADER   = 4'd0,
    PH_RECNUM   = 4'd1,
    PH_RECLEN   = 4'd2,
    PH_RECTYPE  = 4'd3,
    PH_NULLSKIP = 4'd4,
    PH_BOXSKIP  = 4'd5,
    PH_NPARTS   = 4'd6,
    PH_NPOINTS  = 4'd7,
    PH_PARTS    = 4'd8,
    PH_POINTS   = 4'd9,
    PH_DONE     = 4'd10
  } phase_t;

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic [63:0] gather_r, gather_nxt;
  logic [1:0]  ftype_r, ftype_nxt;
  logic [31:0] rec_r, rec_nxt;
  logic [32:0] skip_r, skip_nxt;
  logic [31:0] parts_r, parts_nxt;
  logic [31:0] points_r, points_nxt;
  logic [31:0] elem_r, elem_nxt;
  logic        err_r, err_nxt;

  // result queue
  srp_pkg::result_t q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr1;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             accept, pop;
  srp_pkg::result_t res0, res1;
  logic [1:0]       nres;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [31:0] count_of(input logic [31:0] v);
    count_of = v[31] ? 32'd0 : v;
  endfunction

  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;

  // one byte step
  always_comb begin
    logic [7:0]       b;
    logic [63:0]      g_be, g_le;
    logic [31:0]      t;
    logic [32:0]      s, sdec;
    logic             body_v, fin_v;
    srp_pkg::kind_t   body_kind, fin_kind;
    logic [63:0]      body_val;
    logic [31:0]      body_idx;
    srp_pkg::status_t body_st, fin_st;

    b = in_ch.data_byte;
    if (in_ch.first_byte) begin
      phase_nxt  = PH_HEADER;
      pos_nxt    = '0;
      gather_nxt = '0;
      ftype_nxt  = srp_pkg::FT_NONE;
      rec_nxt    = '0;
      skip_nxt   = '0;
      parts_nxt  = '0;
      points_nxt = '0;
      elem_nxt   = '0;
      err_nxt    = 1'b0;
    end else begin
      phase_nxt  = phase_r;
      pos_nxt    = pos_r;
      gather_nxt = gather_r;
      ftype_nxt  = ftype_r;
      rec_nxt    = rec_r;
      skip_nxt   = skip_r;
      parts_nxt  = parts_r;
      points_nxt = points_r;
      elem_nxt   = elem_r;
      err_nxt    = err_r;
    end

    g_be      = {gather_nxt[55:0], b};
    g_le      = {b, gather_nxt[63:8]};
    t         = '0;
    s         = '0;
    sdec      = '0;
    body_v    = 1'b0;
    body_kind = srp_pkg::K_REC_START;
    body_val  = '0;
    body_idx  = '0;
    body_st   = srp_pkg::ST_OK;
    fin_v     = 1'b0;
    fin_kind  = srp_pkg::K_END;
    fin_st    = srp_pkg::ST_OK;

    if (!err_nxt && phase_nxt != PH_DONE) begin
      unique case (phase_nxt)
        PH_HEADER: begin
          gather_nxt = (pos_nxt < 7'd4) ? g_be : g_le;
          t = gather_nxt[63:32];
          if (pos_nxt == 7'd3 && gather_nxt[31:0] != srp_pkg::FILE_CODE) begin
            err_nxt  = 1'b1;
            body_v   = 1'b1;
            body_kind = srp_pkg::K_ERROR;
            body_st  = srp_pkg::ST_BAD_CODE;
            body_val = 64'(srp_pkg::ST_BAD_CODE);
          end else if (pos_nxt == 7'd35) begin
            if (t == srp_pkg::SHP_POINT) ftype_nxt = srp_pkg::FT_POINT;
            else if (t == srp_pkg::SHP_POLYLINE) ftype_nxt = srp_pkg::FT_POLYLINE;
            else if (t == srp_pkg::SHP_POLYGON) ftype_nxt = srp_pkg::FT_POLYGON;
            else begin
              err_nxt   = 1'b1;
              body_v    = 1'b1;
              body_kind = srp_pkg::K_ERROR;
              body_st   = srp_pkg::ST_BAD_TYPE;
              body_val  = 64'(srp_pkg::ST_BAD_TYPE);
            end
          end else if (pos_nxt >= 7'd43 && pos_nxt <= 7'd67 && pos_nxt[2:0] == 3'd3) begin
            // bound doubles complete at offsets 43, 51, 59, 67
            body_v    = 1'b1;
            body_kind = srp_pkg::kind_t'(4'(7'(pos_nxt - 7'd43) >> 3));
            body_val  = gather_nxt;
          end
          if (pos_nxt >= srp_pkg::HEADER_LAST) begin
            phase_nxt = PH_RECNUM;
            pos_nxt   = '0;
          end else begin
            pos_nxt = pos_nxt + 7'd1;
          end
        end
        PH_RECNUM, PH_RECLEN: begin
          gather_nxt = g_be;
          if (pos_nxt >= 7'd3) begin
            t = gather_nxt[31:0];
            if (phase_nxt == PH_RECNUM) begin
              rec_nxt   = t;
              phase_nxt = PH_RECLEN;
            end else begin
              s         = {count_of(t), 1'b0};
              skip_nxt  = (s < 33'd4) ? 33'd0 : s - 33'd4;
              phase_nxt = PH_RECTYPE;
            end
            pos_nxt = '0;
          end else begin
            pos_nxt = pos_nxt + 7'd1;
          end
        end
        PH_RECTYPE: begin
          gather_nxt = g_le;
          if (pos_nxt >= 7'd3) begin
            pos_nxt = '0;
            if (gather_nxt[63:32] == 32'd0) begin
              // null record
              body_v    = 1'b1;
              phase_nxt = (skip_nxt == 33'd0) ? PH_RECNUM : PH_NULLSKIP;
            end else if (ftype_nxt == srp_pkg::FT_POINT) begin
              body_v     = 1'b1;
              body_val   = 64'd1;
              parts_nxt  = '0;
              points_nxt = 32'd1;
              elem_nxt   = '0;
              phase_nxt  = PH_POINTS;
            end else begin
              skip_nxt  = srp_pkg::BOX_LEN;
              phase_nxt = PH_BOXSKIP;
            end
          end else begin
            pos_nxt = pos_nxt + 7'd1;
          end
        end
        PH_NULLSKIP, PH_BOXSKIP: begin
          sdec     = (skip_nxt != 33'd0) ? skip_nxt - 33'd1 : skip_nxt;
          skip_nxt = sdec;
          if (sdec == 33'd0) begin
            phase_nxt = (phase_nxt == PH_NULLSKIP) ? PH_RECNUM : PH_NPARTS;
            pos_nxt   = '0;
          end
        end
        PH_NPARTS, PH_NPOINTS, PH_PARTS: begin
          gather_nxt = g_le;
          t = gather_nxt[63:32];
          if (pos_nxt >= 7'd3) begin
            pos_nxt = '0;
            if (phase_nxt == PH_NPARTS) begin
              parts_nxt = count_of(t);
              phase_nxt = PH_NPOINTS;
            end else begin
              if (phase_nxt == PH_NPOINTS) begin
                points_nxt = count_of(t);
                body_v     = 1'b1;
                body_val   = 64'(count_of(t));
                body_idx   = parts_nxt;
              end else begin
                body_v    = 1'b1;
                body_kind = srp_pkg::K_PART;
                body_val  = 64'(t);
                body_idx  = elem_nxt;
                elem_nxt  = elem_nxt + 32'd1;
                if (parts_nxt != 32'd0) parts_nxt = parts_nxt - 32'd1;
              end
              // record header done, or last part index taken
              if (phase_nxt == PH_NPOINTS || parts_nxt == 32'd0) begin
                elem_nxt = '0;
                if (parts_nxt != 32'd0) phase_nxt = PH_PARTS;
                else if (points_nxt != 32'd0) phase_nxt = PH_POINTS;
                else phase_nxt = PH_RECNUM;
              end
            end
          end else begin
            pos_nxt = pos_nxt + 7'd1;
          end
        end
        PH_POINTS: begin
          gather_nxt = g_le;
          if (pos_nxt == 7'd7) begin
            body_v    = 1'b1;
            body_kind = srp_pkg::K_POINT_X;
            body_val  = gather_nxt;
            body_idx  = elem_nxt;
            pos_nxt   = pos_nxt + 7'd1;
          end else if (pos_nxt >= 7'd15) begin
            body_v    = 1'b1;
            body_kind = srp_pkg::K_POINT_Y;
            body_val  = gather_nxt;
            body_idx  = elem_nxt;
            elem_nxt  = elem_nxt + 32'd1;
            if (points_nxt != 32'd0) points_nxt = points_nxt - 32'd1;
            if (points_nxt == 32'd0) phase_nxt = PH_RECNUM;
            pos_nxt = '0;
          end else begin
            pos_nxt = pos_nxt + 7'd1;
          end
        end
        default: begin
          phase_nxt = PH_DONE;
          pos_nxt   = '0;
        end
      endcase

      if (in_ch.final_byte && !err_nxt && phase_nxt != PH_DONE) begin
        fin_v = 1'b1;
        if (phase_nxt == PH_RECNUM && pos_nxt == 7'd0) begin
          phase_nxt = PH_DONE;
          pos_nxt   = '0;
        end else begin
          err_nxt  = 1'b1;
          fin_kind = srp_pkg::K_ERROR;
          fin_st   = srp_pkg::ST_TRUNCATED;
        end
      end
    end

    res0.record_number = rec_nxt;
    res1.record_number = rec_nxt;
    res1.kind          = fin_kind;
    res1.value         = 64'(fin_st);
    res1.item_index    = '0;
    res1.status        = fin_st;
    res1.last_of_run   = 1'b1;
    if (body_v) begin
      res0.kind        = body_kind;
      res0.value       = body_val;
      res0.item_index  = body_idx;
      res0.status      = body_st;
      res0.last_of_run = !fin_v;
    end else begin
      res0.kind        = fin_kind;
      res0.value       = 64'(fin_st);
      res0.item_index  = '0;
      res0.status      = fin_st;
      res0.last_of_run = 1'b1;
    end
    nres = 2'(body_v) + 2'(fin_v);
  end

  // queue pointers
  assign wr1 = ptr_inc(wr_r);

  always_comb begin
    logic [1:0] npush;
    npush   = accept ? nres : 2'd0;
    wr_nxt  = (npush == 2'd0) ? wr_r : (npush == 2'd1) ? wr1 : ptr_inc(wr1);
    rd_nxt  = pop ? ptr_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + CNT_W'(npush) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      pos_r    <= '0;
      gather_r <= '0;
      ftype_r  <= srp_pkg::FT_NONE;
      rec_r    <= '0;
      skip_r   <= '0;
      parts_r  <= '0;
      points_r <= '0;
      elem_r   <= '0;
      err_r    <= 1'b0;
      wr_r     <= '0;
      rd_r     <= '0;
      cnt_r    <= '0;
    end else begin
      if (accept) begin
        phase_r  <= phase_nxt;
        pos_r    <= pos_nxt;
        gather_r <= gather_nxt;
        ftype_r  <= ftype_nxt;
        rec_r    <= rec_nxt;
        skip_r   <= skip_nxt;
        parts_r  <= parts_nxt;
        points_r <= points_nxt;
        elem_r   <= elem_nxt;
        err_r    <= err_nxt;
      end
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && nres != 2'd0) q_r[wr_r] <= res0;
    if (accept && nres == 2'd2) q_r[wr1]  <= res1;
  end

  assign in_ch.ready          = (cnt_r <= CNT_ROOM);
  assign out_ch.valid         = (cnt_r != '0);
  assign out_ch.kind          = q_r[rd_r].kind;
  assign out_ch.record_number = q_r[rd_r].record_number;
  assign out_ch.value         = q_r[rd_r].value;
  assign out_ch.item_index    = q_r[rd_r].item_index;
  assign out_ch.status        = q_r[rd_r].status;
  assign out_ch.last_of_run   = q_r[rd_r].last_of_run;

endmodule

`default_nettype wire

### hw/rtl/srp_checker.sv
`default_nettype none

module srp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_kind,
  input wire logic [31:0] out_record_number,
  input wire logic [63:0] out_value,
  input wire logic [31:0] out_item_index,
  input wire logic [1:0]  out_status,
  input wire logic        out_last_of_run
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value)
      && $stable(out_record_number) && $stable(out_item_index) && $stable(out_status)
      && $stable(out_last_of_run))
    else $error("result changed while stalled");

  // nonzero status only on error results
  a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == srp_pkg::K_ERROR) == (out_status != srp_pkg::ST_OK)))
    else $error("status and kind disagree");

  // end and error always close the results of their byte
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == srp_pkg::K_END || out_kind == srp_pkg::K_ERROR)
      |-> out_last_of_run)
    else $error("end or error not last of run");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind shapefile_record_parser srp_checker u_srp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_kind          (out_ch.kind),
  .out_record_number (out_ch.record_number),
  .out_value         (out_ch.value),
  .out_item_index    (out_ch.item_index),
  .out_status        (out_ch.status),
  .out_last_of_run   (out_ch.last_of_run)
);

`default_nettype wire
